// ----- sv/lfu_cache_lookup_insert_defines.svh -----
// ----------------------------------------------------------------------------
// LFU cache assertion macros
// Shared concurrent assertion forms for the LFU cache block.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_LOOKUP_INSERT_DEFINES_SVH
`define LFU_CACHE_LOOKUP_INSERT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LFU_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfu cache assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LFU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfu cache assertion failed");

`endif

// ----- sv/lfu_pkg.sv -----
// ----------------------------------------------------------------------------
// LFU cache package
// Types and constants shared by the entry store, scan unit and top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lfu_pkg;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;
  localparam logic [15:0] COUNT_ONE = 16'd1;
  localparam logic [4:0]  CAPACITY_RESET = 5'd16;

  // Register index as decoded from the word address.
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_t;

  // One entry as read from the store.
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] value;
    logic [15:0] count;
    logic [31:0] stamp;
  } entry_t;

  // Write request to the store; count and stamp are written on every write.
  typedef struct packed {
    logic        en;
    logic        key_en;
    logic        value_en;
    logic [31:0] key;
    logic [31:0] value;
    logic [15:0] count;
    logic [31:0] stamp;
  } wr_req_t;

  // Status collected by the scan unit over one request.
  typedef struct packed {
    logic        match_found;
    logic        victim_found;
    logic        free_found;
    logic [31:0] match_value;
    logic [15:0] match_count;
  } scan_stat_t;

endpackage

`default_nettype wire

// ----- sv/lfu_store.sv -----
// ----------------------------------------------------------------------------
// LFU entry store
// Entry memories with one registered read port and one write port, plus
// per-entry valid bits that reset clears.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfu_store #(
  parameter int ENTRIES = 16,
  parameter int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             rd_en,
  input  wire logic [IW-1:0]    rd_addr,
  output lfu_pkg::entry_t       rd_data,
  input  wire lfu_pkg::wr_req_t wr,
  input  wire logic [IW-1:0]    wr_addr
);

  logic [ENTRIES-1:0] valid_r;
  logic [31:0]        mem_key   [ENTRIES];
  logic [31:0]        mem_value [ENTRIES];
  logic [15:0]        mem_count [ENTRIES];
  logic [31:0]        mem_stamp [ENTRIES];
  lfu_pkg::entry_t    rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (wr.key_en) begin
        mem_key[wr_addr] <= wr.key;
      end
      if (wr.value_en) begin
        mem_value[wr_addr] <= wr.value;
      end
      mem_count[wr_addr] <= wr.count;
      mem_stamp[wr_addr] <= wr.stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r.valid <= valid_r[rd_addr];
      rd_data_r.key   <= mem_key[rd_addr];
      rd_data_r.value <= mem_value[rd_addr];
      rd_data_r.count <= mem_count[rd_addr];
      rd_data_r.stamp <= mem_stamp[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- sv/lfu_scan.sv -----
// ----------------------------------------------------------------------------
// LFU scan unit
// Examines one entry per cycle and keeps the first key match, the lowest free
// slot, the valid count and the least-count, oldest-stamp victim.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lfu_scan #(
  parameter int ENTRIES = 16,
  parameter int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  parameter int CNT_W = $clog2(ENTRIES + 1)
) (
  input  wire logic            clk,
  input  wire logic            start,
  input  wire logic            eval,
  input  wire logic [IW-1:0]   eval_idx,
  input  wire lfu_pkg::entry_t entry,
  input  wire logic [31:0]     req_key,
  output lfu_pkg::scan_stat_t  stat,
  output logic [IW-1:0]        match_idx,
  output logic [IW-1:0]        victim_idx,
  output logic [IW-1:0]        free_idx,
  output logic [CNT_W-1:0]     used
);

  lfu_pkg::scan_stat_t stat_r, stat_nxt;
  logic [IW-1:0]       match_idx_r, match_idx_nxt;
  logic [IW-1:0]       victim_idx_r, victim_idx_nxt;
  logic [IW-1:0]       free_idx_r, free_idx_nxt;
  logic [CNT_W-1:0]    used_r, used_nxt;
  logic [15:0]         victim_count_r, victim_count_nxt;
  logic [31:0]         victim_stamp_r, victim_stamp_nxt;
  logic                better;

  always_comb begin
    stat_nxt         = stat_r;
    match_idx_nxt    = match_idx_r;
    victim_idx_nxt   = victim_idx_r;
    free_idx_nxt     = free_idx_r;
    used_nxt         = used_r;
    victim_count_nxt = victim_count_r;
    victim_stamp_nxt = victim_stamp_r;
    better = !stat_r.victim_found || (entry.count < victim_count_r) ||
             ((entry.count == victim_count_r) && (entry.stamp < victim_stamp_r));
    if (start) begin
      stat_nxt = '0;
      used_nxt = '0;
    end else if (eval) begin
      if (!entry.valid) begin
        if (!stat_r.free_found) begin
          stat_nxt.free_found = 1'b1;
          free_idx_nxt        = eval_idx;
        end
      end else begin
        used_nxt = used_r + CNT_W'(1);
        if (!stat_r.match_found && (entry.key == req_key)) begin
          stat_nxt.match_found = 1'b1;
          stat_nxt.match_value = entry.value;
          stat_nxt.match_count = entry.count;
          match_idx_nxt        = eval_idx;
        end
        if (better) begin
          stat_nxt.victim_found = 1'b1;
          victim_idx_nxt        = eval_idx;
          victim_count_nxt      = entry.count;
          victim_stamp_nxt      = entry.stamp;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    stat_r         <= stat_nxt;
    match_idx_r    <= match_idx_nxt;
    victim_idx_r   <= victim_idx_nxt;
    free_idx_r     <= free_idx_nxt;
    used_r         <= used_nxt;
    victim_count_r <= victim_count_nxt;
    victim_stamp_r <= victim_stamp_nxt;
  end

  assign stat       = stat_r;
  assign match_idx  = match_idx_r;
  assign victim_idx = victim_idx_r;
  assign free_idx   = free_idx_r;
  assign used       = used_r;

endmodule

`default_nettype wire

// ----- sv/lfu_cache_lookup_insert.sv -----
// ----------------------------------------------------------------------------
// LFU cache lookup and insert
// Key-value cache with least-frequently-used replacement and an oldest-touch
// tie break, run by a small sequencer over one shared scan unit.
// ----------------------------------------------------------------------------
// Each request scans all ENTRIES entries and then decides before the next beat
// is accepted: the scan reads one entry per cycle through the single read
// port of the entry memory, then the decide state writes back once the output
// can take the result, and in_stall stays high while the block is not idle.
// No clearing pass is needed after reset, since the valid bits clear at once.
// Capacity is written through the APB port at byte address 0 and values above
// ENTRIES act as ENTRIES. A miss returns hit 0 and value 0.
`timescale 1ns / 1ps
`default_nettype none
`include "lfu_cache_lookup_insert_defines.svh"

module lfu_cache_lookup_insert #(
  parameter int ENTRIES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_cmd,
  input  wire logic signed [31:0] in_key,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_hit,
  output logic signed [31:0]      out_read_value,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CW = (CNT_W > 5) ? CNT_W : 5;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_DECIDE = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    rd_cnt_r, rd_cnt_nxt;
  logic                eval_v_r;
  logic [IW-1:0]       eval_idx_r;
  logic [31:0]         clock_r;
  logic [31:0]         now_r;
  logic                cmd_r;
  logic [31:0]         key_r;
  logic [31:0]         value_r;
  logic [4:0]          capacity_r;
  logic                out_valid_r, out_valid_nxt;
  logic                out_hit_r;
  logic [31:0]         out_value_r;

  logic                accept;
  logic                rd_en;
  logic [IW-1:0]       rd_addr;
  lfu_pkg::entry_t     rd_data;
  lfu_pkg::wr_req_t    wr;
  logic [IW-1:0]       wr_addr;
  lfu_pkg::scan_stat_t stat;
  logic [IW-1:0]       match_idx;
  logic [IW-1:0]       victim_idx;
  logic [IW-1:0]       free_idx;
  logic [CNT_W-1:0]    used;

  logic                can_out;
  logic                decide_go;
  logic [CW-1:0]       cap_ext;
  logic [CW-1:0]       cap_eff;
  logic [15:0]         count_inc;
  logic                res_hit;
  logic [31:0]         res_value;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign can_out  = !out_valid_r || !out_stall;
  assign decide_go = (state_r == ST_DECIDE) && can_out;

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    rd_cnt_nxt = rd_cnt_r;
    rd_en      = 1'b0;
    rd_addr    = rd_cnt_r[IW-1:0];
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt  = ST_SCAN;
          rd_cnt_nxt = '0;
        end
      end
      ST_SCAN: begin
        if (rd_cnt_r == CNT_W'(ENTRIES)) begin
          state_nxt = ST_DECIDE;
        end else begin
          rd_en      = 1'b1;
          rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
        end
      end
      ST_DECIDE: begin
        if (can_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      eval_v_r    <= 1'b0;
      clock_r     <= '0;
      capacity_r  <= lfu_pkg::CAPACITY_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      eval_v_r    <= rd_en;
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        clock_r <= clock_r + 32'd1;
      end
      if (psel && penable && pwrite && pready && (paddr[2] == lfu_pkg::REG_CAPACITY)) begin
        capacity_r <= pwdata[4:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_cnt_r   <= rd_cnt_nxt;
    eval_idx_r <= rd_addr;
    if (accept) begin
      now_r   <= clock_r;
      cmd_r   <= in_cmd;
      key_r   <= $unsigned(in_key);
      value_r <= $unsigned(in_value);
    end
    if (decide_go) begin
      out_hit_r   <= res_hit;
      out_value_r <= res_value;
    end
  end

  // Decision and write-back.
  always_comb begin
    cap_ext   = CW'(capacity_r);
    cap_eff   = (cap_ext > CW'(ENTRIES)) ? CW'(ENTRIES) : cap_ext;
    count_inc = (stat.match_count == lfu_pkg::COUNT_MAX) ? lfu_pkg::COUNT_MAX :
                stat.match_count + 16'd1;
    wr          = '0;
    wr.key      = key_r;
    wr.value    = value_r;
    wr.stamp    = now_r;
    wr.count    = count_inc;
    wr_addr     = match_idx;
    res_hit     = 1'b0;
    res_value   = '0;
    if (cmd_r == lfu_pkg::CMD_GET) begin
      if (stat.match_found) begin
        wr.en     = 1'b1;
        res_hit   = 1'b1;
        res_value = stat.match_value;
      end
    end else if (cap_eff != '0) begin
      if (stat.match_found) begin
        wr.en       = 1'b1;
        wr.value_en = 1'b1;
        res_hit     = 1'b1;
      end else if (stat.victim_found || stat.free_found) begin
        wr.en       = 1'b1;
        wr.key_en   = 1'b1;
        wr.value_en = 1'b1;
        wr.count    = lfu_pkg::COUNT_ONE;
        if ((CW'(used) >= cap_eff) && stat.victim_found) begin
          wr_addr = victim_idx;
        end else if (stat.free_found) begin
          wr_addr = free_idx;
        end else begin
          wr_addr = victim_idx;
        end
      end
    end
    wr.en = wr.en && decide_go;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (decide_go) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  lfu_store #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr),
    .wr_addr (wr_addr)
  );

  lfu_scan #(
    .ENTRIES (ENTRIES),
    .IW      (IW),
    .CNT_W   (CNT_W)
  ) u_scan (
    .clk        (clk),
    .start      (accept),
    .eval       (eval_v_r),
    .eval_idx   (eval_idx_r),
    .entry      (rd_data),
    .req_key    (key_r),
    .stat       (stat),
    .match_idx  (match_idx),
    .victim_idx (victim_idx),
    .free_idx   (free_idx),
    .used       (used)
  );

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = $signed(out_value_r);
  assign pready         = 1'b1;
  assign prdata         = (paddr[2] == lfu_pkg::REG_CAPACITY) ? {27'd0, capacity_r} : 32'd0;

  `LFU_ASSERT_NEXT(a_accept_then_busy, accept, in_stall)
  `LFU_ASSERT_NEXT(a_decide_gives_beat, decide_go, out_valid)
  `LFU_ASSERT_SAME(a_write_only_in_decide, wr.en, (state_r == ST_DECIDE) && can_out)
  `LFU_ASSERT_SAME(a_no_read_outside_scan, rd_en, state_r == ST_SCAN)

endmodule

`default_nettype wire
